// ----- rtl/core/htd_pkg.sv -----
// shared types and constants for the hextile tile decoder
package htd_pkg;

	localparam int TILE_SIZE = 16;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_SUBENC = 3'd1;
	localparam logic [2:0] PH_BG     = 3'd2;
	localparam logic [2:0] PH_FG     = 3'd3;
	localparam logic [2:0] PH_COUNT  = 3'd4;
	localparam logic [2:0] PH_POS    = 3'd5;
	localparam logic [2:0] PH_SIZE   = 3'd6;
	localparam logic [2:0] PH_RAW    = 3'd7;

	localparam int SE_RAW   = 0;
	localparam int SE_BG    = 1;
	localparam int SE_FG    = 2;
	localparam int SE_ANY   = 3;
	localparam int SE_COLOR = 4;

	localparam logic [2:0] REG_LEFT   = 3'd0;
	localparam logic [2:0] REG_TOP    = 3'd1;
	localparam logic [2:0] REG_WIDTH  = 3'd2;
	localparam logic [2:0] REG_HEIGHT = 3'd3;
	localparam logic [2:0] REG_PIXB   = 3'd4;

	localparam int QDEPTH = 2;
	localparam int QAW    = 1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_message;
	} in_word_t;

	typedef struct packed {
		logic        fill_valid;
		logic [15:0] fill_x;
		logic [15:0] fill_y;
		logic [4:0]  fill_w;
		logic [4:0]  fill_h;
		logic [31:0] fill_color;
		logic        rect_done;
	} out_word_t;

	typedef struct packed {
		logic [15:0] left;
		logic [15:0] top;
		logic [15:0] width;
		logic [15:0] height;
		logic [2:0]  pixb;
	} cfg_t;

endpackage

// ----- rtl/core/hextile_tile_decoder.sv -----
// hextile tile decoder top level
// Usage: push one payload word per cycle (data_byte, start_message) while
// full is low; each pushed word yields exactly one result word (fill
// command plus rect_done flag) that appears on the result ports while empty
// is low and leaves on pop. The parser works in the cycle a word is pushed
// and writes its result into a two-entry queue, so a result shows the cycle
// after the push. Throughput is one word per cycle, limited by the single
// parser step per byte. When the receiver stops popping, the queue fills and
// full rises, holding back the sender; parser state is untouched until the
// next push. Reset clears the parser (expecting a subencoding byte), empties
// the queue and loads register defaults: zero rectangle, two bytes per
// pixel. Registers are written over the APB port at byte address 4*index and
// read back the same way; the user writes only while idle, unenforced.
module hextile_tile_decoder import htd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  in_word_t    in_data,
	output logic        empty,
	input  logic        pop,
	output out_word_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t      cfg_q;
	out_word_t res;
	logic      acc_in, acc_out;
	logic [2:0] ridx;

	assign pready  = 1'b1;
	assign acc_in  = push && !full;
	assign acc_out = pop && !empty;
	assign ridx    = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{left: '0, top: '0, width: '0, height: '0, pixb: 3'd2};
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_LEFT:   cfg_q.left   <= pwdata[15:0];
				REG_TOP:    cfg_q.top    <= pwdata[15:0];
				REG_WIDTH:  cfg_q.width  <= pwdata[15:0];
				REG_HEIGHT: cfg_q.height <= pwdata[15:0];
				REG_PIXB:   cfg_q.pixb   <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_LEFT:   prdata = {16'd0, cfg_q.left};
			REG_TOP:    prdata = {16'd0, cfg_q.top};
			REG_WIDTH:  prdata = {16'd0, cfg_q.width};
			REG_HEIGHT: prdata = {16'd0, cfg_q.height};
			REG_PIXB:   prdata = {29'd0, cfg_q.pixb};
			default:    prdata = '0;
		endcase
	end

	htd_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(acc_in), .in_word(in_data), .res(res)
	);

	htd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(acc_in), .wdata(res),
		.rd(acc_out), .rdata(out_data), .full(full), .empty(empty)
	);

endmodule

// ----- rtl/core/htd_front.sv -----
// input side: byte parser and tile walk, one word per cycle while in_valid is high
module htd_front import htd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      in_valid,
	input  in_word_t  in_word,
	output out_word_t res
);

	logic [15:0] tile_left_q, tile_top_q;
	logic [4:0]  tile_w_q, tile_h_q;
	logic [31:0] bg_q, fg_q, acc_q;
	logic [4:0]  flags_q;
	logic [2:0]  phase_q;
	logic [1:0]  cidx_q;
	logic [7:0]  subs_q, pos_q;
	logic [3:0]  col_q, row_q;

	logic [15:0] tl, tt, tl_n, tt_n;
	logic [4:0]  tw_n, th_n, flags_n;
	logic [31:0] bg, fg, bg_n, fg_n, acc, acc_n;
	logic [2:0]  ph, ph_n;
	logic [1:0]  cidx, cidx_n;
	logic [7:0]  subs, subs_n, pos_n, b;
	logic [3:0]  col_n, row_n;
	logic [15:0] coloff, rowoff, remw, remh;
	logic [16:0] colnext, rownext;
	logic [2:0]  epb;
	logic        cdone, tile_over, done;
	logic [1:0]  k;

	always_comb begin
		b = in_word.data_byte;
		if (cfg.pixb == 3'd0) epb = 3'd1;
		else if (cfg.pixb > 3'd4) epb = 3'd4;
		else epb = cfg.pixb;
		tl = tile_left_q; tt = tile_top_q; bg = bg_q; fg = fg_q; acc = acc_q;
		cidx = cidx_q; subs = subs_q; ph = phase_q;
		if (in_word.start_message) begin
			tl = cfg.left; tt = cfg.top; bg = '0; fg = '0; acc = '0;
			cidx = '0; subs = '0; ph = PH_SUBENC;
		end
		tl_n = tl; tt_n = tt; bg_n = bg; fg_n = fg; subs_n = subs; ph_n = ph;
		tw_n = tile_w_q; th_n = tile_h_q; flags_n = flags_q; pos_n = pos_q;
		col_n = col_q; row_n = row_q; cidx_n = cidx;
		// colour byte assembly
		k = cidx;
		acc_n = acc;
		case (k)
			2'd0: acc_n = {24'd0, b};
			2'd1: acc_n[15:8] = b;
			2'd2: acc_n[23:16] = b;
			default: acc_n[31:24] = b;
		endcase
		cdone = ({1'b0, k} + 3'd1) >= epb;
		coloff = tl - cfg.left;
		rowoff = tt - cfg.top;
		remw = cfg.width - coloff;
		remh = cfg.height - rowoff;
		colnext = {1'b0, coloff} + 17'(TILE_SIZE);
		rownext = {1'b0, rowoff} + 17'(TILE_SIZE);
		tile_over = 1'b0;
		res = '0;
		case (ph)
			PH_SUBENC: begin
				acc_n = acc;
				if (coloff < cfg.width && rowoff < cfg.height) begin
					tw_n = (remw > 16'(TILE_SIZE)) ? 5'(TILE_SIZE) : remw[4:0];
					th_n = (remh > 16'(TILE_SIZE)) ? 5'(TILE_SIZE) : remh[4:0];
					flags_n = b[4:0];
					cidx_n = '0; subs_n = '0;
					if (b[SE_RAW]) begin
						col_n = '0; row_n = '0; ph_n = PH_RAW;
					end else if (b[SE_BG]) begin
						ph_n = PH_BG;
					end else begin
						res.fill_valid = 1'b1; res.fill_x = tl; res.fill_y = tt;
						res.fill_w = tw_n; res.fill_h = th_n; res.fill_color = bg;
						if (b[SE_FG]) ph_n = PH_FG;
						else if (b[SE_ANY]) ph_n = PH_COUNT;
						else tile_over = 1'b1;
					end
				end
			end
			PH_BG: begin
				cidx_n = cdone ? 2'd0 : k + 2'd1;
				if (cdone) begin
					bg_n = acc_n; cidx_n = '0;
					res.fill_valid = 1'b1; res.fill_x = tl; res.fill_y = tt;
					res.fill_w = tile_w_q; res.fill_h = tile_h_q; res.fill_color = acc_n;
					if (flags_q[SE_FG]) ph_n = PH_FG;
					else if (flags_q[SE_ANY]) ph_n = PH_COUNT;
					else tile_over = 1'b1;
				end
			end
			PH_FG: begin
				cidx_n = cdone ? 2'd0 : k + 2'd1;
				if (cdone) begin
					fg_n = acc_n;
					if (subs != 8'd0) ph_n = PH_POS;
					else if (flags_q[SE_ANY]) ph_n = PH_COUNT;
					else tile_over = 1'b1;
				end
			end
			PH_COUNT: begin
				acc_n = acc;
				subs_n = b; cidx_n = '0;
				if (b == 8'd0) tile_over = 1'b1;
				else ph_n = flags_q[SE_COLOR] ? PH_FG : PH_POS;
			end
			PH_POS: begin
				acc_n = acc;
				pos_n = b; ph_n = PH_SIZE;
			end
			PH_SIZE: begin
				acc_n = acc;
				res.fill_valid = 1'b1;
				res.fill_x = tl + {12'd0, pos_q[7:4]};
				res.fill_y = tt + {12'd0, pos_q[3:0]};
				res.fill_w = {1'b0, b[7:4]} + 5'd1;
				res.fill_h = {1'b0, b[3:0]} + 5'd1;
				res.fill_color = fg;
				subs_n = subs - 8'd1; cidx_n = '0;
				if (subs_n == 8'd0) tile_over = 1'b1;
				else ph_n = flags_q[SE_COLOR] ? PH_FG : PH_POS;
			end
			PH_RAW: begin
				cidx_n = cdone ? 2'd0 : k + 2'd1;
				if (cdone) begin
					res.fill_valid = 1'b1;
					res.fill_x = tl + {12'd0, col_q};
					res.fill_y = tt + {12'd0, row_q};
					res.fill_w = 5'd1; res.fill_h = 5'd1; res.fill_color = acc_n;
					if ({1'b0, col_q} + 5'd1 >= tile_w_q) begin
						col_n = '0;
						if ({1'b0, row_q} + 5'd1 >= tile_h_q) tile_over = 1'b1;
						else row_n = row_q + 4'd1;
					end else begin
						col_n = col_q + 4'd1;
					end
				end
			end
			default: acc_n = acc;
		endcase
		done = 1'b0;
		if (tile_over) begin
			ph_n = PH_SUBENC;
			if (colnext < {1'b0, cfg.width}) begin
				tl_n = tl + 16'(TILE_SIZE);
			end else begin
				tl_n = cfg.left;
				if (rownext < {1'b0, cfg.height}) tt_n = tt + 16'(TILE_SIZE);
				else begin
					ph_n = PH_IDLE; done = 1'b1;
				end
			end
		end
		res.rect_done = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SUBENC;
			tile_left_q <= '0; tile_top_q <= '0; tile_w_q <= '0; tile_h_q <= '0;
			bg_q <= '0; fg_q <= '0; acc_q <= '0; flags_q <= '0; cidx_q <= '0;
			subs_q <= '0; pos_q <= '0; col_q <= '0; row_q <= '0;
		end else if (in_valid) begin
			phase_q <= ph_n;
			tile_left_q <= tl_n; tile_top_q <= tt_n; tile_w_q <= tw_n; tile_h_q <= th_n;
			bg_q <= bg_n; fg_q <= fg_n; acc_q <= acc_n; flags_q <= flags_n;
			cidx_q <= cidx_n; subs_q <= subs_n; pos_q <= pos_n;
			col_q <= col_n; row_q <= row_n;
		end
	end

endmodule

// ----- rtl/core/htd_queue.sv -----
// result word queue between parser and output side
module htd_queue import htd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr,
	input  out_word_t wdata,
	input  logic      rd,
	output out_word_t rdata,
	output logic      full,
	output logic      empty
);

	out_word_t mem_q [QDEPTH];
	logic [QAW:0] wp_q, rp_q;

	assign empty = (wp_q == rp_q);
	assign full  = (wp_q[QAW] != rp_q[QAW]) && (wp_q[QAW-1:0] == rp_q[QAW-1:0]);
	assign rdata = mem_q[rp_q[QAW-1:0]];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q[QAW-1:0]] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + {{QAW{1'b0}}, 1'b1};
			if (rd) rp_q <= rp_q + {{QAW{1'b0}}, 1'b1};
		end
	end

endmodule

// ----- rtl/core/htd_checker.sv -----
// port-level checks for the hextile tile decoder
module htd_checker import htd_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      push,
	input logic      full,
	input logic      empty,
	input logic      pop,
	input out_word_t out_data
);

	a_not_both: assert property (@(posedge clk) disable iff (!arst_n) !(full && empty))
		else $error("queue full and empty at once");
	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !out_data.fill_valid) |-> (out_data.fill_w == 5'd0))
		else $error("idle word carries a width");
	a_fill_w: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_data.fill_valid) |-> (out_data.fill_w != 5'd0 && out_data.fill_h != 5'd0))
		else $error("fill of zero size");
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> !empty)
		else $error("pushed word left no result");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(out_data))
		else $error("waiting word changed");

endmodule

bind hextile_tile_decoder htd_checker u_htd_checker (
	.clk(clk), .arst_n(arst_n), .push(push), .full(full),
	.empty(empty), .pop(pop), .out_data(out_data)
);

// ----- tb/testbench.sv -----
// self-checking testbench for the hextile tile decoder
`timescale 1ns / 1ps

module testbench;
	import htd_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	in_word_t    in_data = '0;
	logic        empty;
	logic        pop = 1'b0;
	out_word_t   out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	hextile_tile_decoder u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_data(in_data),
		.empty(empty), .pop(pop), .out_data(out_data), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// register copies
	logic [15:0] cfg_left = '0, cfg_top = '0, cfg_width = '0, cfg_height = '0;
	logic [2:0]  cfg_pixb = 3'd2;

	// decoder state
	logic [15:0] tl_x = '0, tl_y = '0;
	logic [4:0]  tl_w = '0, tl_h = '0;
	logic [31:0] bg_col = '0, fg_col = '0, col_acc = '0;
	logic [4:0]  se_flags = '0;
	logic [2:0]  phase = PH_SUBENC;
	logic [1:0]  col_idx = '0;
	logic [7:0]  subs_left = '0, pos_byte = '0;
	logic [3:0]  raw_col = '0, raw_row = '0;

	in_word_t  byte_queue[$];
	out_word_t fill_queue[$];
	int        errors = 0;
	bit        no_idle = 0;
	int        hold_req = 0;
	int        items_added = 0;

	function automatic int eff_pixb();
		if (cfg_pixb == 0) return 1;
		if (cfg_pixb > 4) return 4;
		return cfg_pixb;
	endfunction

	function automatic bit take_colour_byte(logic [7:0] b);
		int k;
		k = col_idx;
		if (k == 0) col_acc = {24'd0, b};
		else col_acc = col_acc | ({24'd0, b} << (8 * k));
		if (k + 1 >= eff_pixb()) begin
			col_idx = 2'd0;
			return 1;
		end
		col_idx = 2'(k + 1);
		return 0;
	endfunction

	function automatic bit next_tile();
		int coloff, rowoff;
		coloff = (tl_x - cfg_left) & 16'hFFFF;
		rowoff = (tl_y - cfg_top) & 16'hFFFF;
		phase = PH_SUBENC;
		if (coloff + TILE_SIZE < cfg_width) begin
			tl_x = tl_x + 16'd16;
			return 0;
		end
		tl_x = cfg_left;
		if (rowoff + TILE_SIZE < cfg_height) begin
			tl_y = tl_y + 16'd16;
			return 0;
		end
		phase = PH_IDLE;
		return 1;
	endfunction

	function automatic void after_bg();
		col_idx = 2'd0;
		if (se_flags[SE_FG]) phase = PH_FG;
		else if (se_flags[SE_ANY]) phase = PH_COUNT;
		else phase = PH_IDLE;
	endfunction

	function automatic out_word_t make_fill(logic [15:0] x, logic [15:0] y, logic [4:0] w,
			logic [4:0] h, logic [31:0] c);
		out_word_t r;
		r = '0;
		r.fill_valid = 1'b1;
		r.fill_x = x;
		r.fill_y = y;
		r.fill_w = w;
		r.fill_h = h;
		r.fill_color = c;
		return r;
	endfunction

	function automatic out_word_t decode_byte(in_word_t w);
		out_word_t r;
		logic [7:0] b;
		bit over;
		int coloff, rowoff;
		r = '0;
		b = w.data_byte;
		over = 0;
		if (w.start_message) begin
			tl_x = cfg_left;
			tl_y = cfg_top;
			bg_col = '0;
			fg_col = '0;
			col_acc = '0;
			col_idx = '0;
			subs_left = '0;
			phase = PH_SUBENC;
		end
		case (phase)
			PH_SUBENC: begin
				coloff = (tl_x - cfg_left) & 16'hFFFF;
				rowoff = (tl_y - cfg_top) & 16'hFFFF;
				if (!(coloff >= cfg_width || rowoff >= cfg_height)) begin
					tl_w = (cfg_width - coloff > 16) ? 5'd16 : 5'(cfg_width - coloff);
					tl_h = (cfg_height - rowoff > 16) ? 5'd16 : 5'(cfg_height - rowoff);
					se_flags = b[4:0];
					col_idx = 2'd0;
					subs_left = 8'd0;
					if (se_flags[SE_RAW]) begin
						raw_col = 4'd0;
						raw_row = 4'd0;
						phase = PH_RAW;
					end else if (se_flags[SE_BG]) begin
						phase = PH_BG;
					end else begin
						r = make_fill(tl_x, tl_y, tl_w, tl_h, bg_col);
						after_bg();
						over = (phase == PH_IDLE);
					end
				end
			end
			PH_BG: begin
				if (take_colour_byte(b)) begin
					bg_col = col_acc;
					r = make_fill(tl_x, tl_y, tl_w, tl_h, bg_col);
					after_bg();
					over = (phase == PH_IDLE);
				end
			end
			PH_FG: begin
				if (take_colour_byte(b)) begin
					fg_col = col_acc;
					if (subs_left != 0) phase = PH_POS;
					else if (se_flags[SE_ANY]) phase = PH_COUNT;
					else over = 1;
				end
			end
			PH_COUNT: begin
				subs_left = b;
				col_idx = 2'd0;
				if (b == 0) over = 1;
				else phase = se_flags[SE_COLOR] ? PH_FG : PH_POS;
			end
			PH_POS: begin
				pos_byte = b;
				phase = PH_SIZE;
			end
			PH_SIZE: begin
				r = make_fill(tl_x + {12'd0, pos_byte[7:4]}, tl_y + {12'd0, pos_byte[3:0]},
					5'(b[7:4]) + 5'd1, 5'(b[3:0]) + 5'd1, fg_col);
				subs_left = subs_left - 8'd1;
				col_idx = 2'd0;
				if (subs_left == 0) over = 1;
				else phase = se_flags[SE_COLOR] ? PH_FG : PH_POS;
			end
			PH_RAW: begin
				if (take_colour_byte(b)) begin
					r = make_fill(tl_x + {12'd0, raw_col}, tl_y + {12'd0, raw_row},
						5'd1, 5'd1, col_acc);
					if (raw_col + 1 >= tl_w) begin
						raw_col = 4'd0;
						if (raw_row + 1 >= tl_h) over = 1;
						else raw_row = raw_row + 4'd1;
					end else begin
						raw_col = raw_col + 4'd1;
					end
				end
			end
			default: ;
		endcase
		if (over) r.rect_done = next_tile();
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (push && !full) begin
			fill_queue.push_back(decode_byte(in_data));
			void'(byte_queue.pop_front());
		end
		if (arst_n && byte_queue.size() != 0 && (no_idle || $urandom_range(99) >= 25)) begin
			push <= 1'b1;
			in_data <= byte_queue[0];
		end else begin
			push <= 1'b0;
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h got %0h", $realtime, name, want, got);
			errors++;
		end
	endfunction

	// long receiver stall, counted in cycles
	int hold_left = 0;
	int hold_seen = 0;
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 400;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor
	always @(posedge clk) begin
		out_word_t want;
		if (pop && !empty) begin
			if (fill_queue.size() == 0) begin
				$display("%0t: unexpected word %p", $realtime, out_data);
				errors++;
			end else begin
				want = fill_queue.pop_front();
				check_field("fill_valid", {31'd0, want.fill_valid}, {31'd0, out_data.fill_valid});
				check_field("fill_x", {16'd0, want.fill_x}, {16'd0, out_data.fill_x});
				check_field("fill_y", {16'd0, want.fill_y}, {16'd0, out_data.fill_y});
				check_field("fill_w", {27'd0, want.fill_w}, {27'd0, out_data.fill_w});
				check_field("fill_h", {27'd0, want.fill_h}, {27'd0, out_data.fill_h});
				check_field("fill_color", want.fill_color, out_data.fill_color);
				check_field("rect_done", {31'd0, want.rect_done}, {31'd0, out_data.rect_done});
			end
		end
		if (hold_left > 0) begin
			pop <= 1'b0;
		end else begin
			pop <= no_idle || ($urandom_range(99) >= 25);
		end
	end

	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic add_byte(logic [7:0] b, bit start);
		in_word_t w;
		w.data_byte = b;
		w.start_message = start;
		byte_queue.push_back(w);
		items_added++;
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_LEFT:   cfg_left = v[15:0];
			REG_TOP:    cfg_top = v[15:0];
			REG_WIDTH:  cfg_width = v[15:0];
			REG_HEIGHT: cfg_height = v[15:0];
			default:    cfg_pixb = v[2:0];
		endcase
	endtask

	task automatic drain();
		while (byte_queue.size() != 0 || fill_queue.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_rect(logic [15:0] l, logic [15:0] t, logic [15:0] w, logic [15:0] h,
			logic [2:0] pb);
		drain();
		reg_write(REG_LEFT, ({$urandom} & 32'hFFFF0000) | {16'd0, l});
		reg_write(REG_TOP, {16'd0, t});
		reg_write(REG_WIDTH, {16'd0, w});
		reg_write(REG_HEIGHT, {16'd0, h});
		reg_write(REG_PIXB, ({$urandom} & 32'hFFFFFFF8) | {29'd0, pb});
	endtask

	task automatic add_colour();
		repeat (eff_pixb()) add_byte(8'($urandom_range(255)), 0);
	endtask

	// one well-formed tile with random content
	task automatic add_tile(int tw, int th, bit first);
		logic [7:0] se;
		int n;
		se = 8'($urandom_range(255));
		if ($urandom_range(99) < 70) se[SE_RAW] = 1'b0;
		add_byte(se, first);
		if (se[SE_RAW]) begin
			repeat (tw * th) add_colour();
		end else begin
			if (se[SE_BG]) add_colour();
			if (se[SE_FG]) add_colour();
			if (se[SE_ANY]) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(5);
				if (n > 40) n = 40 + $urandom_range(1);
				add_byte(8'(n), 0);
				repeat (n) begin
					if (se[SE_COLOR]) add_colour();
					add_byte(8'($urandom_range(255)), 0);
					add_byte(8'($urandom_range(255)), 0);
				end
			end
		end
	endtask

	task automatic add_rect();
		int tx, ty, tiles;
		tiles = 0;
		for (ty = 0; ty < cfg_height; ty += 16)
			for (tx = 0; tx < cfg_width; tx += 16) begin
				add_tile((cfg_width - tx > 16) ? 16 : cfg_width - tx,
					(cfg_height - ty > 16) ? 16 : cfg_height - ty, tiles == 0);
				tiles++;
			end
		if (tiles == 0) add_byte(8'($urandom_range(255)), 1);
	endtask

	task automatic add_noise(int n);
		repeat (n) add_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
	endtask

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(3))
			0: return 16'd0;
			1: return 16'hFFFF - 16'($urandom_range(20));
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	function automatic logic [15:0] pick_size();
		case ($urandom_range(19))
			0: return 16'd0;
			1: return 16'd16;
			2: return 16'd17 + 16'($urandom_range(30));
			default: return 16'd1 + 16'($urandom_range(20));
		endcase
	endfunction

	initial begin
		int phase_no;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// zero rectangle right after reset: everything ignored
		add_byte(8'h00, 1'b1);
		add_byte(8'hFF, 1'b0);
		// 3x2 at the wrapping corner, one byte per pixel, raw with all bits set
		set_rect(16'hFFFE, 16'hFFFF, 16'd3, 16'd2, 3'd1);
		add_byte(8'hFF, 1'b1);
		add_byte(8'h00, 0); add_byte(8'hFF, 0); add_byte(8'h80, 0);
		add_byte(8'h01, 0); add_byte(8'h7F, 0); add_byte(8'hFE, 0);
		add_byte(8'h55, 0);
		// background, foreground, zero subrects
		add_byte(8'h0E, 1'b1); add_byte(8'hAA, 0); add_byte(8'h55, 0); add_byte(8'h00, 0);
		// coloured subrects at the extremes
		add_byte(8'h1A, 1'b1); add_byte(8'h01, 0); add_byte(8'h02, 0);
		add_byte(8'hFF, 0); add_byte(8'hFF, 0); add_byte(8'hFF, 0);
		add_byte(8'h00, 0); add_byte(8'h00, 0); add_byte(8'h00, 0);
		// plain background fill
		add_byte(8'h00, 1'b1);
		// odd pixel sizes
		set_rect(16'd0, 16'd0, 16'd1, 16'd1, 3'd0);
		add_byte(8'h03, 1'b1); add_byte(8'hC3, 0);
		set_rect(16'd5, 16'd9, 16'd1, 16'd1, 3'd7);
		add_byte(8'h01, 1'b1); repeat (4) add_byte(8'hA5, 0);

		// largest rectangle and a mid-rectangle register change, fed by noise
		set_rect(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd4);
		add_byte(8'h00, 1'b1);
		add_noise(30);
		drain();
		reg_write(REG_WIDTH, 32'd40);
		add_noise(20);

		phase_no = 0;
		while (items_added < 1250) begin
			set_rect(pick_coord(), pick_coord(), pick_size(), pick_size(),
				$urandom_range(9) < 7 ? 3'($urandom_range(1, 4)) : 3'($urandom_range(7)));
			no_idle = (phase_no == 3);
			if (phase_no == 5) hold_req++;
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(9) == 0) add_noise($urandom_range(1, 15));
				else add_rect();
				if ($urandom_range(3) == 0) add_noise($urandom_range(1, 4));
			end
			phase_no++;
		end
		drain();
		no_idle = 0;
		repeat (20) @(posedge clk);
		if (errors == 0 && fill_queue.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/htd_pkg.sv
rtl/core/htd_front.sv
rtl/core/htd_queue.sv
rtl/core/hextile_tile_decoder.sv
rtl/core/htd_checker.sv
tb/testbench.sv
